>>> sv/plst_pkg.sv
// Shared types and constants for the ordered palette list.
// Used by plst_cell, plst_select and ordered_palette_list; no dependencies.
`timescale 1ns / 1ps

package plst_pkg;

  localparam int DATA_W     = 32;   // colour word width
  localparam int SLOT_W     = 8;    // list position width
  localparam int OUT_CNT_W  = 9;    // entry_count field width
  localparam int REQ_W      = 2;    // req_type field width
  localparam int LIST_DEPTH = 256;  // default number of cells
  localparam int GROUP      = 16;   // leaves per first-level select node

  // Operation codes carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_READ    = 2'd0,
    REQ_INSERT  = 2'd1,
    REQ_DELETE  = 2'd2,
    REQ_REPLACE = 2'd3
  } req_t;

  // Command broadcast to every cell in the accept cycle
  typedef struct packed {
    logic              ins;     // insert, not refused
    logic              del;     // delete, not refused
    logic              rep;     // replace
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] colour;
  } cmd_t;

endpackage

>>> sv/ordered_palette_list.sv
// Top level of the ordered palette list: command decode, cell chain, result
// select and output register. Depends on plst_pkg, plst_cell, plst_select.
//
// Usage:
//   in_*  : one transaction per operation. in_tuser carries req_type
//           (read, insert, delete, replace), in_tdata slot and colour_word.
//   out_* : one transaction per operation with the entry at the slot after
//           the operation, the entry count and the refused flag.
//   Each operation runs in order: the accept edge updates every cell at
//   once (each cell loads its neighbor, the colour, or holds), then the
//   first level of the select tree latches, and then the output register
//   loads and out_tvalid rises.
//   A new operation is accepted only once the previous result has loaded
//   the output register.
//   The output register holds a result until out_tready takes it; the next
//   operation may be accepted meanwhile, and its result waits in the select
//   stage until the register frees, with in_tready low.
//   Reset clears all entries and the count to zero, and empties the
//   output register. Slots are not checked against the count; an insert on
//   a full list or a delete with one or no entries is refused and changes
//   nothing.
`timescale 1ns / 1ps

module ordered_palette_list #(
  parameter int LIST_DEPTH = plst_pkg::LIST_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] slot, [39:8] colour_word
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] read_word, [40:32] entry_count, zero above
  output logic [0:0]  out_tuser   // [0] refused
);

  localparam int CntW = $clog2(LIST_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GATHER,
    PH_SELECT
  } phase_t;

  phase_t                        phase_r;
  logic [CntW-1:0]               count_r;
  logic [CntW-1:0]               count_nxt;
  logic [plst_pkg::SLOT_W-1:0]   slot_r;
  logic                          refused_r;
  logic                          out_valid_r;
  logic [plst_pkg::DATA_W-1:0]   out_word_r;
  logic [plst_pkg::OUT_CNT_W-1:0] out_count_r;
  logic                          out_refused_r;

  logic                          in_acc;
  logic                          out_free;
  plst_pkg::req_t                req;
  logic                          full;
  logic                          low;
  logic                          refuse;
  plst_pkg::cmd_t                cmd;
  logic [plst_pkg::DATA_W-1:0]   entry_word [LIST_DEPTH];
  logic [plst_pkg::DATA_W-1:0]   hit_word   [LIST_DEPTH];
  logic [plst_pkg::DATA_W-1:0]   sel_word;

  assign in_tready = (phase_r == PH_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Decode the operation and its refusal
  assign req    = plst_pkg::req_t'(in_tuser);
  assign full   = (count_r == CntW'(LIST_DEPTH));
  assign low    = (count_r <= CntW'(1));
  assign refuse = ((req == plst_pkg::REQ_INSERT) && full) ||
                  ((req == plst_pkg::REQ_DELETE) && low);

  always_comb begin
    cmd.ins    = in_acc && (req == plst_pkg::REQ_INSERT) && !full;
    cmd.del    = in_acc && (req == plst_pkg::REQ_DELETE) && !low;
    cmd.rep    = in_acc && (req == plst_pkg::REQ_REPLACE);
    cmd.slot   = in_tdata[7:0];
    cmd.colour = in_tdata[39:8];
  end

  // Advance the count
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CntW'(1);
    end else if (cmd.del) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Chain of cells, each wired to its neighbors
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic [plst_pkg::DATA_W-1:0] left_word;
    logic [plst_pkg::DATA_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_left
      assign left_word = entry_word[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_right
      assign right_word = entry_word[i+1];
    end

    plst_cell #(
      .LIST_DEPTH (LIST_DEPTH),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .cmd_cnt    (count_r),
      .sel_slot   (slot_r),
      .left_word  (left_word),
      .right_word (right_word),
      .entry_word (entry_word[i]),
      .hit_word   (hit_word[i])
    );
  end

  // Gather the word at the pending slot
  plst_select #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_select (
    .clk      (clk),
    .hit_word (hit_word),
    .sel_word (sel_word)
  );

  // Sequence one operation and hold the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, or drop the one just taken
      if ((phase_r == PH_SELECT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (phase_r)
        PH_IDLE: begin
          if (in_acc) begin
            phase_r <= PH_GATHER;
          end
        end
        PH_GATHER: begin
          phase_r <= PH_SELECT;
        end
        PH_SELECT: begin
          if (out_free) begin
            phase_r <= PH_IDLE;
          end
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  // Capture the operation's slot and flag; load the result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r    <= in_tdata[7:0];
      refused_r <= refuse;
    end
    if ((phase_r == PH_SELECT) && out_free) begin
      out_word_r    <= sel_word;
      out_count_r   <= plst_pkg::OUT_CNT_W'(count_r);
      out_refused_r <= refused_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'd0, out_count_r, out_word_r};
  assign out_tuser[0] = out_refused_r;

  // Count stays within the store
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(LIST_DEPTH))
    else $error("entry count beyond list depth");

  // An accepted insert on a list with room grows the count by one
  a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (req == plst_pkg::REQ_INSERT) && !full)
      |=> (count_r == $past(count_r) + CntW'(1)))
    else $error("insert did not advance count");

  // Deletes never empty a list that has entries
  a_no_empty : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(count_r) != '0) |-> (count_r != '0))
    else $error("count dropped to zero");

  // A result appears only from the select phase
  a_out_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(phase_r) == PH_SELECT))
    else $error("result loaded outside select phase");

  // No operation is taken while another is in flight
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> !in_acc)
    else $error("operation accepted while busy");

endmodule

>>> sv/plst_cell.sv
// One cell of the shift-register list: holds one colour word and loads from
// its left or right neighbor or from the command. Depends on plst_pkg.
`timescale 1ns / 1ps

module plst_cell #(
  parameter int LIST_DEPTH = plst_pkg::LIST_DEPTH,
  parameter int IDX        = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plst_pkg::cmd_t                    cmd,
  input  logic [$clog2(LIST_DEPTH+1)-1:0]   cmd_cnt,     // count before the operation
  input  logic [plst_pkg::SLOT_W-1:0]       sel_slot,    // slot of the pending result
  input  logic [plst_pkg::DATA_W-1:0]       left_word,   // entry of cell IDX-1
  input  logic [plst_pkg::DATA_W-1:0]       right_word,  // entry of cell IDX+1
  output logic [plst_pkg::DATA_W-1:0]       entry_word,
  output logic [plst_pkg::DATA_W-1:0]       hit_word     // entry if selected, else zero
);

  localparam int CntW = $clog2(LIST_DEPTH + 1);
  localparam int CmpW = (CntW > plst_pkg::SLOT_W) ? CntW + 1 : plst_pkg::SLOT_W + 1;
  localparam logic [CmpW-1:0] IdxW = CmpW'(IDX);

  logic [plst_pkg::DATA_W-1:0] entry_r;
  logic [plst_pkg::DATA_W-1:0] entry_nxt;
  logic [CmpW-1:0]             slot_w;
  logic [CmpW-1:0]             cnt_w;
  logic                        at_slot;
  logic                        above_slot;

  assign slot_w     = CmpW'(cmd.slot);
  assign cnt_w      = CmpW'(cmd_cnt);
  assign at_slot    = (IdxW == slot_w);
  assign above_slot = (IdxW > slot_w);

  // Pick the next entry: colour, a neighbor, or hold
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (at_slot) begin
        entry_nxt = cmd.colour;
      end else if (above_slot && (IdxW <= cnt_w)) begin
        entry_nxt = left_word;
      end
    end else if (cmd.del) begin
      if ((at_slot || above_slot) && ((IdxW + CmpW'(1)) < cnt_w)) begin
        entry_nxt = right_word;
      end
    end else if (cmd.rep && at_slot) begin
      entry_nxt = cmd.colour;
    end
  end

  // Hold the entry; the store clears at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_word = entry_r;
  assign hit_word   = (IdxW == CmpW'(sel_slot)) ? entry_r : '0;

endmodule

>>> sv/plst_select.sv
// Registered two-level OR tree that gathers the one selected cell word.
// Depends on plst_pkg.
`timescale 1ns / 1ps

module plst_select #(
  parameter int LIST_DEPTH = plst_pkg::LIST_DEPTH
) (
  input  logic                        clk,
  input  logic [plst_pkg::DATA_W-1:0] hit_word [LIST_DEPTH],
  output logic [plst_pkg::DATA_W-1:0] sel_word
);

  localparam int Group  = plst_pkg::GROUP;
  localparam int Groups = (LIST_DEPTH + Group - 1) / Group;

  logic [plst_pkg::DATA_W-1:0] group_r   [Groups];
  logic [plst_pkg::DATA_W-1:0] group_nxt [Groups];

  // First level: OR each group of cells
  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      group_nxt[g] = '0;
      for (int k = 0; k < Group; k++) begin
        if (g * Group + k < LIST_DEPTH) begin
          group_nxt[g] = group_nxt[g] | hit_word[g * Group + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < Groups; g++) begin
      group_r[g] <= group_nxt[g];
    end
  end

  // Second level: OR the group registers
  always_comb begin
    sel_word = '0;
    for (int g = 0; g < Groups; g++) begin
      sel_word = sel_word | group_r[g];
    end
  end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for ordered_palette_list: directed table, then random
// insert/delete/replace/read traffic checked against an in-bench list model.
// Depends on plst_pkg and the ordered_palette_list RTL.
`timescale 1ns / 1ps

module testbench;

  // Expected contents of one result transaction
  typedef struct {
    logic [31:0] word;
    logic [8:0]  count;
    logic        refused;
  } result_t;

  // One directed operation; known marks rows whose answer is typed in
  typedef struct {
    plst_pkg::req_t op;
    logic [7:0]     slot;
    logic [31:0]    colour;
    bit             known;
    logic [31:0]    word;
    logic [8:0]     count;
    logic           refused;
  } op_row_t;

  localparam int DIRECTED_OPS = 19;
  localparam int RANDOM_OPS   = 750;
  localparam int FILL_END     = 350;
  localparam int DRAIN_END    = 670;
  localparam int LONG_HOLD    = 80;

  // Directed sequence: empty list, single entry, slot past the count, shifts
  op_row_t directed_ops [0:DIRECTED_OPS-1] = '{
    '{plst_pkg::REQ_READ,    8'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, 9'd0, 1'b0},
    '{plst_pkg::REQ_READ,    8'd255, 32'h0000_0000, 1'b1, 32'h0000_0000, 9'd0, 1'b0},
    '{plst_pkg::REQ_DELETE,  8'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, 9'd0, 1'b1},
    '{plst_pkg::REQ_INSERT,  8'd0,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 9'd1, 1'b0},
    '{plst_pkg::REQ_DELETE,  8'd0,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 9'd1, 1'b1},
    '{plst_pkg::REQ_INSERT,  8'd255, 32'hA5A5_A5A5, 1'b1, 32'hA5A5_A5A5, 9'd2, 1'b0},
    '{plst_pkg::REQ_REPLACE, 8'd255, 32'h0000_0000, 1'b1, 32'h0000_0000, 9'd2, 1'b0},
    '{plst_pkg::REQ_REPLACE, 8'd0,   32'h5A5A_5A5A, 1'b1, 32'h5A5A_5A5A, 9'd2, 1'b0},
    '{plst_pkg::REQ_INSERT,  8'd0,   32'h1234_5678, 1'b1, 32'h1234_5678, 9'd3, 1'b0},
    '{plst_pkg::REQ_READ,    8'd1,   32'hFFFF_FFFF, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_READ,    8'd2,   32'h0000_0000, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_INSERT,  8'd1,   32'hC3C3_C3C3, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_DELETE,  8'd0,   32'h0000_0000, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_DELETE,  8'd200, 32'hFFFF_FFFF, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_READ,    8'd255, 32'h0000_0000, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_REPLACE, 8'd128, 32'h0F0F_0F0F, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_INSERT,  8'd2,   32'hF0F0_F0F0, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_DELETE,  8'd1,   32'h0000_0000, 1'b0, 32'h0, 9'd0, 1'b0},
    '{plst_pkg::REQ_READ,    8'd0,   32'h0000_0000, 1'b0, 32'h0, 9'd0, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] slot, [39:8] colour_word
  logic [1:0]  in_tuser;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [31:0] read_word, [40:32] entry_count
  logic [0:0]  out_tuser;  // [0] refused

  // List model state
  logic [31:0] palette [0:255];
  logic [8:0]  list_len;

  result_t pending_results [$];
  int      error_count;
  int      mismatch_count;
  bit      quiet_tail;
  bit      hold_request;

  ordered_palette_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Apply one operation to the list model and return its answer
  function automatic result_t apply_list_op(plst_pkg::req_t op, logic [7:0] slot,
                                            logic [31:0] colour);
    result_t res;
    int      i;
    int      n;
    res.refused = 1'b0;
    n = int'(list_len);
    case (op)
      plst_pkg::REQ_INSERT: begin
        if (n >= 256) begin
          res.refused = 1'b1;
        end else begin
          n = n + 1;
          for (i = n - 1; i > int'(slot); i--) palette[i] = palette[i-1];
          palette[slot] = colour;
        end
      end
      plst_pkg::REQ_DELETE: begin
        if (n <= 1) begin
          res.refused = 1'b1;
        end else begin
          for (i = int'(slot); i + 1 < n; i++) palette[i] = palette[i+1];
          n = n - 1;
        end
      end
      plst_pkg::REQ_REPLACE: palette[slot] = colour;
      default: ;
    endcase
    list_len  = n[8:0];
    res.word  = palette[slot];
    res.count = list_len;
    return res;
  endfunction

  // Count a failure and report the first few
  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (mismatch_count < 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Offer one transaction, record its answer at acceptance, maybe idle after
  task automatic send_op(plst_pkg::req_t op, logic [7:0] slot, logic [31:0] colour,
                         result_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= {colour, slot};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(want);
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Compare each result transaction against the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", 32'h0, out_tdata[31:0]);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.word)
          note_mismatch("read_word", want.word, out_tdata[31:0]);
        if (out_tdata[40:32] !== want.count)
          note_mismatch("entry_count", {23'd0, want.count}, {23'd0, out_tdata[40:32]});
        if (out_tuser[0] !== want.refused)
          note_mismatch("refused", {31'd0, want.refused}, {31'd0, out_tuser[0]});
      end
    end
  end

  // Result side: random stall bursts, one long hold on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed table, then fill, drain and mixed traffic
  initial begin : stimulus
    result_t        want;
    plst_pkg::req_t op;
    logic [7:0]     slot;
    int             roll;
    int             ins_pct;
    int             del_pct;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    error_count    = 0;
    mismatch_count = 0;
    quiet_tail     = 1'b0;
    hold_request   = 1'b0;
    list_len       = '0;
    for (int i = 0; i < 256; i++) palette[i] = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int k = 0; k < DIRECTED_OPS; k++) begin
      want = apply_list_op(directed_ops[k].op, directed_ops[k].slot, directed_ops[k].colour);
      if (directed_ops[k].known) begin
        want.word    = directed_ops[k].word;
        want.count   = directed_ops[k].count;
        want.refused = directed_ops[k].refused;
      end
      send_op(directed_ops[k].op, directed_ops[k].slot, directed_ops[k].colour, want);
    end

    // Random traffic: grow to a full list, shrink to one entry, then mix
    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (k < FILL_END) begin
        ins_pct = 88;
        del_pct = 4;
      end else if (k < DRAIN_END) begin
        ins_pct = 2;
        del_pct = 92;
      end else begin
        ins_pct = 25;
        del_pct = 25;
        quiet_tail = 1'b1;
      end

      // Let the block back up against a held result port
      if (k == 120) hold_request = 1'b1;

      // Drain everything in flight before carrying on
      if (k == 250 || k == 500) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(negedge clk);
      end

      roll = $urandom_range(0, 99);
      if (roll < ins_pct) op = plst_pkg::REQ_INSERT;
      else if (roll < ins_pct + del_pct) op = plst_pkg::REQ_DELETE;
      else if (roll[0]) op = plst_pkg::REQ_REPLACE;
      else op = plst_pkg::REQ_READ;

      if (list_len != 0 && $urandom_range(0, 1) == 1)
        slot = 8'($urandom_range(0, int'(list_len) - 1));
      else
        slot = 8'($urandom_range(0, 255));

      roll = $urandom;
      want = apply_list_op(op, slot, roll);
      send_op(op, slot, roll, want);
    end

    // Wait out every result, then the pipeline depth
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
sv/plst_pkg.sv
sv/plst_cell.sv
sv/plst_select.sv
sv/ordered_palette_list.sv
verif/testbench.sv
